/* hw/rtl/lsb_stego_byte_embedder_unit_defines.svh */
// ----------------------------------------------------------------------------
// LSB embedder assertion macros
// Shared concurrent assertion forms, clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LSB_STEGO_BYTE_EMBEDDER_UNIT_DEFINES_SVH
`define LSB_STEGO_BYTE_EMBEDDER_UNIT_DEFINES_SVH

`define LSBE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define LSBE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/lsbe_pkg.sv */
// ----------------------------------------------------------------------------
// LSB embedder package
// Shared constants, phase codes and the record passed from front to back.
// ----------------------------------------------------------------------------
package lsbe_pkg;

    localparam int HEADER_BYTES = 54;
    localparam int POS_W        = 27;
    localparam int MAGIC_BITS   = 16;
    localparam int LENGTH_BITS  = 32;
    localparam int MAGIC_W      = 16;
    localparam int LEN_W        = 24;
    localparam int ADDR_W       = 3;

    localparam logic [MAGIC_W-1:0] MAGIC_RESET  = 16'h232A;
    localparam logic [LEN_W-1:0]   LENGTH_RESET = 24'd1;

    localparam logic REG_MAGIC  = 1'b0;
    localparam logic REG_LENGTH = 1'b1;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_MAGIC  = 3'd1,
        PH_LENGTH = 3'd2,
        PH_SECRET = 3'd3,
        PH_TAIL   = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0] pix;
        logic [7:0] sec;
        phase_t     ph;
        logic [4:0] pos;
        logic       taken;
    } item_t;

endpackage

/* hw/rtl/lsb_stego_byte_embedder_unit.sv */
// ----------------------------------------------------------------------------
// LSB steganography byte embedder
// Path: an accepted beat is written to the queue, then to the output register.
// Throughput: one beat per cycle while m_tready holds; a full queue drops s_tready.
// Reset: synchronous, active low; phase header, position zero, registers 0x232A and 1.
// ----------------------------------------------------------------------------
`include "lsb_stego_byte_embedder_unit_defines.svh"

module lsb_stego_byte_embedder_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [15:0]                  s_tdata,  // pixel_byte, secret_byte
    input  logic [0:0]                   s_tuser,  // start_of_image
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [7:0]                   m_tdata,  // out_byte
    output logic [3:0]                   m_tuser,  // secret_taken, phase
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lsbe_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic [lsbe_pkg::MAGIC_W-1:0] magic_reg;
    logic [lsbe_pkg::LEN_W-1:0]   length_reg;
    logic                         cfg_write;
    logic                         in_fire;
    logic                         q_not_full;
    logic                         q_not_empty;
    logic                         q_pop;
    lsbe_pkg::item_t              front_item;
    lsbe_pkg::item_t              q_item;
    logic                         out_taken;
    logic [2:0]                   out_phase;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign s_tready  = q_not_full;
    assign in_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg  <= lsbe_pkg::MAGIC_RESET;
            length_reg <= lsbe_pkg::LENGTH_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                lsbe_pkg::REG_MAGIC: begin
                    magic_reg <= pwdata[lsbe_pkg::MAGIC_W-1:0];
                end
                lsbe_pkg::REG_LENGTH: begin
                    length_reg <= pwdata[lsbe_pkg::LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            lsbe_pkg::REG_MAGIC:  prdata = {{(32 - lsbe_pkg::MAGIC_W){1'b0}}, magic_reg};
            lsbe_pkg::REG_LENGTH: prdata = {{(32 - lsbe_pkg::LEN_W){1'b0}}, length_reg};
            default:              prdata = 32'd0;
        endcase
    end

    lsbe_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .pix        (s_tdata[7:0]),
        .sec        (s_tdata[15:8]),
        .sop        (s_tuser[0]),
        .secret_len (length_reg),
        .item       (front_item)
    );

    lsbe_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_fire),
        .push_data (front_item),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_item)
    );

    lsbe_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_not_empty),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .magic_word (magic_reg),
        .secret_len (length_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (m_tdata),
        .out_taken  (out_taken),
        .out_phase  (out_phase)
    );

    assign m_tuser = {out_phase, out_taken};

    `LSBE_ASSERT_SAME(a_taken_in_secret, m_tvalid && m_tuser[0], m_tuser[3:1] == 3'(lsbe_pkg::PH_SECRET), "secret taken outside the secret phase")
    `LSBE_ASSERT_SAME(a_full_means_stalled, !s_tready, m_tvalid, "queue full while the output is empty")
    `LSBE_ASSERT_NEXT(a_pop_fills_output, q_pop, m_tvalid, "popped beat did not reach the output")

endmodule

/* hw/rtl/lsbe_front.sv */
// ----------------------------------------------------------------------------
// LSB embedder front end
// Tracks the stream phase and position and classifies each accepted beat.
// ----------------------------------------------------------------------------
module lsbe_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_fire,
    input  logic [7:0]                    pix,
    input  logic [7:0]                    sec,
    input  logic                          sop,
    input  logic [lsbe_pkg::LEN_W-1:0]    secret_len,
    output lsbe_pkg::item_t               item
);

    typedef struct packed {
        lsbe_pkg::phase_t               ph;
        logic [lsbe_pkg::POS_W-1:0]     pos;
    } phpos_t;

    function automatic phpos_t skip_done(phpos_t p, logic [lsbe_pkg::LEN_W-1:0] len);
        phpos_t r;
        r = p;
        case (p.ph)
            lsbe_pkg::PH_HEADER: begin
                if (p.pos >= lsbe_pkg::POS_W'(lsbe_pkg::HEADER_BYTES)) begin
                    r.ph  = lsbe_pkg::PH_MAGIC;
                    r.pos = '0;
                end
            end
            lsbe_pkg::PH_MAGIC: begin
                if (p.pos >= lsbe_pkg::POS_W'(lsbe_pkg::MAGIC_BITS)) begin
                    r.ph  = lsbe_pkg::PH_LENGTH;
                    r.pos = '0;
                end
            end
            lsbe_pkg::PH_LENGTH: begin
                if (p.pos >= lsbe_pkg::POS_W'(lsbe_pkg::LENGTH_BITS)) begin
                    r.ph  = (len == '0) ? lsbe_pkg::PH_TAIL : lsbe_pkg::PH_SECRET;
                    r.pos = '0;
                end
            end
            lsbe_pkg::PH_SECRET: begin
                if (p.pos >= {len, 3'b000}) begin
                    r.ph  = lsbe_pkg::PH_TAIL;
                    r.pos = '0;
                end
            end
            default: begin
                r.ph = lsbe_pkg::PH_TAIL;
            end
        endcase
        return r;
    endfunction

    phpos_t state_reg;
    phpos_t state_next;
    phpos_t start_pp;
    phpos_t cur_pp;
    phpos_t adv_pp;

    always_comb begin
        start_pp = sop ? phpos_t'{lsbe_pkg::PH_HEADER, '0} : state_reg;
        cur_pp   = skip_done(start_pp, secret_len);
        adv_pp.ph  = cur_pp.ph;
        adv_pp.pos = cur_pp.pos + lsbe_pkg::POS_W'(1);
        if (cur_pp.ph == lsbe_pkg::PH_TAIL) begin
            state_next = cur_pp;
        end else begin
            state_next = skip_done(adv_pp, secret_len);
        end
    end

    always_comb begin
        item.pix   = pix;
        item.sec   = sec;
        item.ph    = cur_pp.ph;
        item.pos   = cur_pp.pos[4:0];
        item.taken = (cur_pp.ph == lsbe_pkg::PH_SECRET) && (cur_pp.pos[2:0] == 3'b000);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= phpos_t'{lsbe_pkg::PH_HEADER, '0};
        end else if (in_fire) begin
            state_reg <= state_next;
        end
    end

endmodule

/* hw/rtl/lsbe_queue.sv */
// ----------------------------------------------------------------------------
// LSB embedder queue
// Two-entry FIFO of classified beats between the front and back ends.
// ----------------------------------------------------------------------------
module lsbe_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  lsbe_pkg::item_t push_data,
    output logic            not_full,
    input  logic            pop,
    output logic            not_empty,
    output lsbe_pkg::item_t pop_data
);

    lsbe_pkg::item_t slot_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;

    assign not_full  = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

/* hw/rtl/lsbe_back.sv */
// ----------------------------------------------------------------------------
// LSB embedder back end
// Replaces the pixel LSB except in header and tail and holds the output beat.
// ----------------------------------------------------------------------------
module lsbe_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  lsbe_pkg::item_t               q_item,
    output logic                          q_pop,
    input  logic [lsbe_pkg::MAGIC_W-1:0]  magic_word,
    input  logic [lsbe_pkg::LEN_W-1:0]    secret_len,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    out_byte,
    output logic                          out_taken,
    output logic [2:0]                    out_phase
);

    logic [7:0]                        held_secret_reg;
    logic [lsbe_pkg::LENGTH_BITS-1:0]  len_field;
    logic [7:0]                        secret_src;
    logic                              emb_bit;
    logic [7:0]                        byte_next;
    logic                              out_valid_reg;
    logic [7:0]                        out_byte_reg;
    logic                              out_taken_reg;
    logic [2:0]                        out_phase_reg;

    assign q_pop      = q_valid && (!out_valid_reg || out_ready);
    assign len_field  = {{(lsbe_pkg::LENGTH_BITS - lsbe_pkg::LEN_W){1'b0}}, secret_len};
    assign secret_src = q_item.taken ? q_item.sec : held_secret_reg;

    always_comb begin
        emb_bit   = 1'b0;
        byte_next = q_item.pix;
        case (q_item.ph)
            lsbe_pkg::PH_MAGIC: begin
                emb_bit   = magic_word[~q_item.pos[3:0]];
                byte_next = {q_item.pix[7:1], emb_bit};
            end
            lsbe_pkg::PH_LENGTH: begin
                emb_bit   = len_field[~q_item.pos];
                byte_next = {q_item.pix[7:1], emb_bit};
            end
            lsbe_pkg::PH_SECRET: begin
                emb_bit   = secret_src[~q_item.pos[2:0]];
                byte_next = {q_item.pix[7:1], emb_bit};
            end
            default: begin
                byte_next = q_item.pix;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_secret_reg <= 8'd0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (q_pop && q_item.taken) begin
                held_secret_reg <= q_item.sec;
            end
            if (q_pop) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_byte_reg  <= byte_next;
            out_taken_reg <= q_item.taken;
            out_phase_reg <= 3'(q_item.ph);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_taken = out_taken_reg;
    assign out_phase = out_phase_reg;

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// LSB steganography byte embedder testbench
// Streams image bytes through the embedder and predicts each output beat:
// the header passthrough, the magic word, the length field, the secret bytes
// and the tail. It runs directed extremes and special cases first, then
// random images under changing register settings. Both stream sides are
// throttled at random.
// ----------------------------------------------------------------------------
module testbench;
    import lsbe_pkg::*;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       taken;
        phase_t     ph;
    } stego_beat_t;

    typedef enum {RX_OPEN, RX_CHOPPY, RX_PATTERN} rx_mode_t;

    class stego_scoreboard;
        logic [MAGIC_W-1:0] magic;
        logic [LEN_W-1:0]   slen;
        phase_t             cur_phase;
        logic [POS_W-1:0]   pos;
        logic [7:0]         held;
        stego_beat_t        expected_q[$];
        int                 errors;

        function new();
            magic     = MAGIC_RESET;
            slen      = LENGTH_RESET;
            cur_phase = PH_HEADER;
            pos       = '0;
            held      = '0;
            errors    = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        function void set_register(logic idx, logic [31:0] value);
            if (idx == REG_MAGIC) begin
                magic = value[MAGIC_W-1:0];
            end else begin
                slen = value[LEN_W-1:0];
            end
        endfunction

        function logic [31:0] read_register(logic idx);
            if (idx == REG_MAGIC) begin
                return {16'h0000, magic};
            end
            return {8'h00, slen};
        endfunction

        function int unsigned phase_bytes(phase_t p);
            case (p)
                PH_HEADER: return HEADER_BYTES;
                PH_MAGIC:  return MAGIC_BITS;
                PH_LENGTH: return LENGTH_BITS;
                PH_SECRET: return 32'(slen) * 8;
                default:   return 0;
            endcase
        endfunction

        function void skip_done();
            while (cur_phase != PH_TAIL && pos >= phase_bytes(cur_phase)) begin
                cur_phase = phase_t'(cur_phase + 3'd1);
                pos = '0;
            end
        endfunction

        function void note_input(logic [7:0] pix, logic [7:0] sec, logic sop);
            stego_beat_t exp_beat;
            logic [31:0] len_field;
            len_field = {8'h00, slen};
            if (sop) begin
                cur_phase = PH_HEADER;
                pos = '0;
            end
            skip_done();
            exp_beat.out_byte = pix;
            exp_beat.taken    = 1'b0;
            exp_beat.ph       = cur_phase;
            case (cur_phase)
                PH_MAGIC:  exp_beat.out_byte[0] = magic[4'd15 - pos[3:0]];
                PH_LENGTH: exp_beat.out_byte[0] = len_field[5'd31 - pos[4:0]];
                PH_SECRET: begin
                    if (pos[2:0] == 3'd0) begin
                        held = sec;
                        exp_beat.taken = 1'b1;
                    end
                    exp_beat.out_byte[0] = held[3'd7 - pos[2:0]];
                end
                default: ;
            endcase
            if (cur_phase != PH_TAIL) begin
                pos = pos + 1'b1;
                skip_done();
            end
            expected_q.push_back(exp_beat);
        endfunction

        task check_result(logic [7:0] data, logic [3:0] user);
            stego_beat_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected beat, byte %02h user %h", data, user));
                return;
            end
            want = expected_q.pop_front();
            if (data !== want.out_byte) begin
                report($sformatf("out_byte %02h, expected %02h", data, want.out_byte));
            end
            if (user[0] !== want.taken) begin
                report($sformatf("secret_taken %b, expected %b", user[0], want.taken));
            end
            if (user[3:1] !== want.ph) begin
                report($sformatf("phase %0d, expected %0d", user[3:1], want.ph));
            end
        endtask
    endclass

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [15:0]         s_tdata  = '0;  // pixel_byte, secret_byte
    logic [0:0]          s_tuser  = '0;  // start_of_image
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [7:0]          m_tdata;        // out_byte
    logic [3:0]          m_tuser;        // secret_taken, phase
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ADDR_W-1:0]   paddr    = '0;
    logic [31:0]         pwdata   = '0;
    logic [31:0]         prdata;
    logic                pready;

    stego_scoreboard sb = new();
    int       items_sent = 0;
    int       burst_left = 0;
    bit       gaps_on    = 1'b1;
    int       hold_left  = 0;
    rx_mode_t rx_mode    = RX_OPEN;
    int       rx_tick    = 0;

    lsb_stego_byte_embedder_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_input(s_tdata[7:0], s_tdata[15:8], s_tuser[0]);
            end
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata, m_tuser);
            end
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            rx_tick++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_OPEN:    m_tready <= 1'b1;
                    RX_CHOPPY:  m_tready <= ($urandom_range(0, 3) != 0);
                    RX_PATTERN: m_tready <= ((rx_tick % 7) >= 3);
                    default:    m_tready <= 1'b1;
                endcase
            end
        end
    end

    initial begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = gaps_on ? $urandom_range(0, 5) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
    endtask

    task automatic send_beat(logic [7:0] pix, logic [7:0] sec, logic sop);
        pace();
        s_tvalid <= 1'b1;
        s_tdata  <= {sec, pix};
        s_tuser  <= sop;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // A run of n beats; noise > 0 scatters stray start marks at one in noise.
    task automatic send_run(int n, bit mark_first, int noise);
        logic sop;
        for (int i = 0; i < n; i++) begin
            sop = (i == 0) && mark_first;
            if (noise > 0 && $urandom_range(1, noise) == 1) begin
                sop = 1'b1;
            end
            send_beat(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), sop);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_read_check(logic idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== sb.read_register(idx)) begin
            sb.report($sformatf("register %0d reads %h, expected %h",
                                idx, prdata, sb.read_register(idx)));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apb_write(logic idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        apb_read_check(idx);
    endtask

    initial begin
        int frame_base;
        int kind;
        int cap;
        logic [15:0] magic_val;
        logic [23:0] slen_val;

        frame_base = HEADER_BYTES + MAGIC_BITS + LENGTH_BITS;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        rx_mode = RX_OPEN;
        gaps_on = 1'b0;
        apb_read_check(REG_MAGIC);
        apb_read_check(REG_LENGTH);

        // No start mark after reset, then a start mark part way into the header.
        send_beat(8'h00, 8'hFF, 1'b0);
        send_beat(8'hFF, 8'h00, 1'b0);
        send_beat(8'h55, 8'hAA, 1'b0);
        send_beat(8'hAA, 8'h55, 1'b0);
        send_beat(8'h01, 8'h80, 1'b0);
        send_beat(8'hFE, 8'h7F, 1'b1);
        send_beat(8'h80, 8'h01, 1'b0);
        send_run(frame_base + 8 + 6, 1'b1, 0);

        // Zero secret length: the tail follows the length field directly.
        wait_idle();
        apb_write(REG_MAGIC, 32'h0000_FFFF);
        apb_write(REG_LENGTH, 32'h0000_0000);
        send_beat(8'hFF, 8'hFF, 1'b1);
        send_run(frame_base + 8, 1'b0, 0);

        // Largest length, then shrunk below the position already reached.
        wait_idle();
        apb_write(REG_MAGIC, 32'h0000_0000);
        apb_write(REG_LENGTH, 32'h00FF_FFFF);
        send_run(frame_base + 40, 1'b1, 0);
        wait_idle();
        apb_write(REG_LENGTH, 32'd2);
        send_run(8, 1'b0, 0);

        // Length changed in the middle of the first secret byte.
        wait_idle();
        apb_write(REG_LENGTH, 32'h00FF_FFFF);
        send_run(frame_base + 4, 1'b1, 0);
        wait_idle();
        apb_write(REG_LENGTH, 32'd3);
        send_run(30, 1'b0, 0);

        // Long receiver hold-off while the sender keeps offering beats.
        wait_idle();
        gaps_on = 1'b1;
        hold_left = 300;
        send_run(frame_base + 16, 1'b1, 0);

        while (items_sent < 1000) begin
            wait_idle();
            case ($urandom_range(0, 9))
                0:       magic_val = 16'h0000;
                1:       magic_val = 16'hFFFF;
                default: magic_val = 16'($urandom_range(0, 16'hFFFF));
            endcase
            case ($urandom_range(0, 9))
                0:       slen_val = 24'hFF_FFFF;
                1:       slen_val = 24'd0;
                2:       slen_val = 24'($urandom_range(7, 40));
                default: slen_val = 24'($urandom_range(1, 6));
            endcase
            apb_write(REG_MAGIC, {16'h0000, magic_val});
            apb_write(REG_LENGTH, {8'h00, slen_val});
            cap = (slen_val <= 12) ? int'(slen_val) : 6;
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            gaps_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 3)) begin
                kind = $urandom_range(0, 9);
                if (kind == 0) begin
                    send_run($urandom_range(1, frame_base + cap * 8), 1'b1, 0);
                end else if (kind == 1) begin
                    send_run($urandom_range(1, 10), 1'b0, 2);
                end else begin
                    send_run(frame_base + cap * 8 + $urandom_range(0, 12), 1'b1, 400);
                end
            end
        end

        wait_idle();
        repeat (6) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
